>>> rtl/salu_pkg.sv
// Shared types and constants for the saturating integer ALU.
// No dependencies.
package salu_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_ADD = 2'd0;
   localparam opcode_type OP_SUB = 2'd1;
   localparam opcode_type OP_MUL = 2'd2;
   localparam opcode_type OP_DIV = 2'd3;

endpackage

>>> rtl/salu_if.sv
// Valid/ready channel interfaces for the ALU request and response items.
// Depends on salu_pkg.
interface salu_req_if #(parameter int DATA_WIDTH = salu_pkg::DATA_WIDTH_DEFAULT);
   logic                         valid;
   logic                         ready;
   salu_pkg::opcode_type         opcode;
   logic signed [DATA_WIDTH-1:0] operand_a;
   logic signed [DATA_WIDTH-1:0] operand_b;

   modport source (output valid, opcode, operand_a, operand_b, input ready);
   modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface salu_rsp_if #(parameter int DATA_WIDTH = salu_pkg::DATA_WIDTH_DEFAULT);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

>>> rtl/saturating_integer_alu.sv
// Saturating signed add/sub/mul/div, pipelined one bit per stage.
// Depends on salu_pkg and salu_if.
//
//   channel  dir  payload                        handshake
//   req      in   opcode, operand_a, operand_b   valid/ready
//   rsp      out  result                         valid/ready
//
// One item enters per cycle unless rsp is stalled. Each of the
// DATA_WIDTH middle stages does one shift-add multiply step and one
// restoring divide step. Reset (synchronous) clears the valid bits only.
// A stalled rsp freezes the whole pipe; req.ready drops only then.
module saturating_integer_alu #(
   parameter int DATA_WIDTH = salu_pkg::DATA_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   salu_req_if.sink   req,
   salu_rsp_if.source rsp
);
   import salu_pkg::*;

   localparam int W = DATA_WIDTH;

   typedef struct packed {
      opcode_type     op;
      logic           neg;
      logic           special;
      logic [W-1:0]   res;
      logic [W-1:0]   ma;
      logic [W-1:0]   mb;
      logic [2*W-1:0] acc;
      logic [W-1:0]   q;
      logic [W-1:0]   rem;
   } stage_type;

   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   logic            en;
   logic [W:0]      v_ff;
   stage_type       s_ff [0:W];
   stage_type       s_in [0:W];
   logic            rsp_valid_ff;
   logic [W-1:0]    rsp_result_ff;
   logic [W-1:0]    rsp_result_in;

   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // entry stage: add/sub done here, magnitudes and divide specials prepared
   always_comb begin
      logic [W:0]   sum;
      logic         sa, sb;
      stage_type    e;
      sa = req.operand_a[W-1];
      sb = req.operand_b[W-1];
      e = '0;
      e.op  = req.opcode;
      e.neg = sa ^ sb;
      e.ma  = sa ? W'(-req.operand_a) : W'(req.operand_a);
      e.mb  = sb ? W'(-req.operand_b) : W'(req.operand_b);
      e.q   = e.ma;
      if (req.opcode == OP_SUB) begin
         sum = {sa, req.operand_a} - {sb, req.operand_b};
      end else begin
         sum = {sa, req.operand_a} + {sb, req.operand_b};
      end
      case (req.opcode)
         OP_ADD, OP_SUB: begin
            if (sum[W] != sum[W-1]) e.res = sum[W] ? MIN_VAL : MAX_VAL;
            else                    e.res = sum[W-1:0];
         end
         OP_DIV: begin
            if (req.operand_b == '0) begin
               e.special = 1'b1;
               e.res = (!sa && req.operand_a != '0) ? MAX_VAL : MIN_VAL;
            end else if (req.operand_a == MIN_VAL && req.operand_b == '1) begin
               e.special = 1'b1;
               e.res = MAX_VAL;
            end
         end
         default: e.res = '0;
      endcase
      s_in[0] = e;
   end

   genvar k;
   generate
      for (k = 1; k <= W; k++) begin : g_step
         always_comb begin
            logic [W:0] t;
            stage_type  s;
            s = s_ff[k-1];
            if (s.mb[k-1]) s.acc = s.acc + ({{W{1'b0}}, s.ma} << (k-1));
            t = {s.rem, s.q[W-1]};
            if (t >= {1'b0, s.mb}) begin
               t = t - {1'b0, s.mb};
               s.q = {s.q[W-2:0], 1'b1};
            end else begin
               s.q = {s.q[W-2:0], 1'b0};
            end
            s.rem = t[W-1:0];
            s_in[k] = s;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[W-1:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= W; i++) s_ff[i] <= s_in[i];
      end
   end

   // final selection and multiply clamp
   always_comb begin
      logic [2*W-1:0] limit;
      stage_type      f;
      f = s_ff[W];
      limit = {{W{1'b0}}, MAX_VAL} + {{(2*W-1){1'b0}}, f.neg};
      case (f.op)
         OP_ADD, OP_SUB: rsp_result_in = f.res;
         OP_MUL: begin
            if (f.acc > limit) rsp_result_in = f.neg ? MIN_VAL : MAX_VAL;
            else if (f.neg)    rsp_result_in = W'(-f.acc);
            else               rsp_result_in = f.acc[W-1:0];
         end
         OP_DIV: begin
            if (f.special)  rsp_result_in = f.res;
            else if (f.neg) rsp_result_in = -f.q;
            else            rsp_result_in = f.q;
         end
         default: rsp_result_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) rsp_result_ff <= rsp_result_in;
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.result = rsp_result_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid_ff && v_ff == '0)
      else $error("pipe not empty after reset");
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> v_ff[0])
      else $error("accepted item lost at entry");
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> $stable(v_ff) && $stable(rsp_result_ff))
      else $error("pipe moved during stall");
   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      (en && v_ff[W]) |=> rsp_valid_ff)
      else $error("item dropped at output");

endmodule

>>> tb/sv/testbench.sv
// Testbench for the saturating integer ALU: directed corner items, then random items
// under three idle patterns and one long output stall. Depends on salu_pkg, salu_if.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import salu_pkg::*;

   localparam int W = DATA_WIDTH_DEFAULT;
   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;

   salu_req_if #(.DATA_WIDTH(W)) req ();
   salu_rsp_if #(.DATA_WIDTH(W)) rsp ();

   saturating_integer_alu #(.DATA_WIDTH(W)) i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   always #1 clock = ~clock;

   logic signed [W-1:0] expected_results[$];
   int unsigned errors = 0;
   int unsigned results_seen = 0;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned hold_total = 0;
   int unsigned hold_count = 0;
   int unsigned op_count[4] = '{0, 0, 0, 0};

   initial begin
      req.valid <= 1'b0;
      req.opcode <= OP_ADD;
      req.operand_a <= '0;
      req.operand_b <= '0;
   end

   function automatic logic signed [W-1:0] sat(input logic signed [2*W+1:0] v);
      if (v > $signed({{(W+2){1'b0}}, MAXV})) return MAXV;
      if (v < $signed({{(W+2){1'b1}}, MINV})) return MINV;
      return v[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] alu_result(input opcode_type op,
         input logic signed [W-1:0] a, input logic signed [W-1:0] b);
      logic signed [2*W+1:0] wa, wb;
      wa = a;
      wb = b;
      case (op)
         OP_ADD: return sat(wa + wb);
         OP_SUB: return sat(wa - wb);
         OP_MUL: return sat(wa * wb);
         default: begin
            if (b == 0) return (a > 0) ? MAXV : MINV;
            return sat(wa / wb);   // truncates toward zero; MIN/-1 clamps
         end
      endcase
   endfunction

   // receiver: random ready plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_count < hold_total) begin
         hold_count <= hold_count + 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            $error("result with no item outstanding: result=%0d", rsp.result);
            errors <= errors + 1;
         end else if (rsp.result !== expected_results[0]) begin
            $error("result mismatch: expected %0d actual %0d",
                   expected_results[0], rsp.result);
            errors <= errors + 1;
            void'(expected_results.pop_front());
         end else begin
            void'(expected_results.pop_front());
         end
      end
   end

   // valid stays high between back-to-back items; it drops only while idling
   task automatic send_op(input opcode_type op, input logic signed [W-1:0] a,
         input logic signed [W-1:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.opcode <= op;
      req.operand_a <= a;
      req.operand_b <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expected_results.push_back(alu_result(op, a, b));
      op_count[op] = op_count[op] + 1;
   endtask

   function automatic logic signed [W-1:0] rand_operand();
      logic signed [W-1:0] v;
      case ($urandom_range(5))
         0: v = MAXV - $urandom_range(2);
         1: v = MINV + $urandom_range(2);
         2: v = $signed(W'($urandom_range(4))) - 2;
         3: v = $signed(W'($urandom_range(65535))) - 32768;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic test_directed();
      logic signed [W-1:0] vals[6] = '{MAXV, MINV, 0, 1, -1, 7};
      send_op(OP_ADD, MAXV, 1);
      send_op(OP_ADD, MINV, -1);
      send_op(OP_ADD, MAXV, MINV);
      send_op(OP_SUB, 0, MINV);
      send_op(OP_SUB, MINV, 1);
      send_op(OP_SUB, -1, MINV);
      send_op(OP_MUL, MAXV, MAXV);
      send_op(OP_MUL, MINV, -1);
      send_op(OP_MUL, MINV, 1);
      send_op(OP_MUL, 65536, -32768);
      send_op(OP_MUL, 0, MINV);
      send_op(OP_DIV, MINV, -1);
      send_op(OP_DIV, 5, 0);
      send_op(OP_DIV, 0, 0);
      send_op(OP_DIV, -5, 0);
      send_op(OP_DIV, -7, 2);
      send_op(OP_DIV, 7, -2);
      send_op(OP_DIV, MINV, MAXV);
      for (int i = 0; i < 6; i++) send_op(OP_DIV, vals[i], vals[5 - i]);
   endtask

   task automatic test_random(input int unsigned n);
      for (int i = 0; i < n; i++)
         send_op(opcode_type'($urandom_range(3)), rand_operand(), rand_operand());
   endtask

   task automatic test_backpressure();
      wait_drain();
      hold_total = 200;
      fork
         test_random(100);
      join
   endtask

   task automatic wait_drain();
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idle_pct = 11;
      rsp_idle_pct = 50;
      test_directed();
      test_random(450);
      req_idle_pct = 50;
      rsp_idle_pct = 11;
      test_random(450);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random(450);
      test_backpressure();
      wait_drain();
      repeat (2 * W + 8) @(posedge clock);
      $display("covered %0d add, %0d sub, %0d mul, %0d div items; %0d results checked",
               op_count[0], op_count[1], op_count[2], op_count[3], results_seen);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("testbench NOT OK");
      $finish;
   end
endmodule
